/* hw/rtl/lla_pkg.sv */
package lla_pkg;

  // Widths fixed by the register and the item fields
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CNT_W       = CFG_W;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned IDX_OUT_W   = 3;

  localparam logic [CFG_W-1:0] WORKER_COUNT_RESET = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FILL_TAKE,
    ST_SCAN_FIRST,
    ST_SCAN_NEXT,
    ST_WRITE_BACK
  } state_t;

  typedef enum logic [1:0] {
    RD_FILL,
    RD_LAST,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_inc;
    logic    take;
    logic    cmp;
    logic    wb;
  } cmd_t;

  typedef struct packed {
    logic fill_go;
    logic use_last;
    logic scan_more;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/lla_intf.sv */
interface lla_job_if;
  logic        valid;
  logic        ready;
  logic [31:0] job_size;

  modport source (output valid, output job_size, input ready);
  modport sink (input valid, input job_size, output ready);
endinterface

interface lla_result_if #(
  parameter int unsigned LOAD_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           worker_index;
  logic [LOAD_BITS-1:0] worker_load;

  modport source (output valid, output worker_index, output worker_load, input ready);
  modport sink (input valid, input worker_index, input worker_load, output ready);
endinterface

/* hw/rtl/lla_ctrl.sv */
module lla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lla_pkg::status_t status,
  output lla_pkg::cmd_t   cmd
);
  import lla_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel = RD_SCAN;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        cmd.rd_en = 1'b1;
        if (status.fill_go) begin
          cmd.rd_sel = RD_FILL;
          state_next = ST_FILL_TAKE;
        end else if (status.use_last) begin
          cmd.rd_sel = RD_LAST;
          state_next = ST_SCAN_FIRST;
        end else begin
          cmd.rd_sel   = RD_SCAN;
          cmd.scan_inc = 1'b1;
          state_next   = ST_SCAN_FIRST;
        end
      end
      ST_FILL_TAKE: begin
        cmd.take   = 1'b1;
        state_next = ST_WRITE_BACK;
      end
      ST_SCAN_FIRST, ST_SCAN_NEXT: begin
        // first returned load seeds the search, the rest compare against it
        cmd.take = (state == ST_SCAN_FIRST);
        cmd.cmp  = (state == ST_SCAN_NEXT);
        if (status.scan_more) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_SCAN;
          cmd.scan_inc = 1'b1;
          state_next   = ST_SCAN_NEXT;
        end else begin
          state_next = ST_WRITE_BACK;
        end
      end
      ST_WRITE_BACK: begin
        if (status.out_free) begin
          cmd.wb     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lla_datapath.sv */
module lla_datapath #(
  parameter int unsigned MAX_WORKERS = 8,
  parameter int unsigned LOAD_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lla_pkg::CFG_W-1:0]          cfg_wdata,
  input  lla_pkg::cmd_t                      cmd,
  output lla_pkg::status_t                   status,
  input  logic [lla_pkg::SIZE_W-1:0]         job_size,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [lla_pkg::IDX_OUT_W-1:0]      worker_index,
  output logic [LOAD_BITS-1:0]               worker_load
);
  import lla_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_WORKERS);

  logic [CFG_W-1:0]     worker_count;
  logic [CNT_W-1:0]     fill_count;
  logic [IDX_W-1:0]     last_pick;
  logic                 have_last;
  logic                 is_fill;
  logic [SIZE_W-1:0]    size;
  logic [CNT_W-1:0]     scan_idx;

  logic [LOAD_BITS-1:0] mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] vld;
  logic [LOAD_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     rd_idx;

  logic [LOAD_BITS-1:0] best;
  logic [IDX_W-1:0]     pick;

  logic [CNT_W-1:0]     active_n;
  logic [IDX_W-1:0]     rd_addr;
  logic [LOAD_BITS:0]   sum_wide;
  logic [LOAD_BITS-1:0] sum_sat;

  // zero means one worker; clamp to the number of load slots
  always_comb begin
    if (worker_count == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(worker_count) > 32'(MAX_WORKERS)) begin
      active_n = CNT_W'(MAX_WORKERS);
    end else begin
      active_n = worker_count;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_FILL: rd_addr = IDX_W'(fill_count);
      RD_LAST: rd_addr = last_pick;
      RD_SCAN: rd_addr = IDX_W'(scan_idx);
      default: rd_addr = last_pick;
    endcase
  end

  assign sum_wide = {1'b0, best} + (LOAD_BITS + 1)'(size);
  assign sum_sat  = sum_wide[LOAD_BITS] ? {LOAD_BITS{1'b1}} : sum_wide[LOAD_BITS-1:0];

  assign status.fill_go   = (fill_count < active_n);
  assign status.use_last  = have_last && (32'(last_pick) < 32'(active_n));
  assign status.scan_more = (scan_idx < active_n);
  assign status.out_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= WORKER_COUNT_RESET;
      fill_count   <= '0;
      last_pick    <= '0;
      have_last    <= 1'b0;
      vld          <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        worker_count <= cfg_wdata;
      end
      if (cmd.wb) begin
        vld[pick] <= 1'b1;
        res_valid <= 1'b1;
        if (is_fill) begin
          fill_count <= fill_count + CNT_W'(1);
        end else begin
          last_pick <= pick;
          have_last <= 1'b1;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // load store: one read port with registered data, one write port
  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      mem[pick] <= sum_sat;
    end
    if (cmd.rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size     <= job_size;
      scan_idx <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (cmd.start) begin
      is_fill <= status.fill_go;
    end
    if (cmd.take || (cmd.cmp && (rd_data < best))) begin
      best <= rd_data;
      pick <= rd_idx;
    end
    if (cmd.wb) begin
      worker_index <= IDX_OUT_W'(pick);
      worker_load  <= sum_sat;
    end
  end

endmodule

/* hw/rtl/least_loaded_assigner.sv */
// Least-loaded job assigner. Each accepted item carries a job size; the block
// gives the job to one worker and returns that worker's index together with
// its new running load, which saturates at all ones. The first items fill
// workers 0 up to the worker count in order; later items go to the lightest
// worker, keeping the previous choice on a tie and otherwise taking the lowest
// index. Set worker_count (1 to 8, zero acts as one, above 8 acts as 8) while
// the block is idle. One item is in work at a time. A fill item reads the load
// of the next unfilled worker, takes it and writes it back with the job size
// added. A search item first reads the previous pick to seed the search, then
// every worker, one a cycle through one comparator; with no previous pick to
// seed from, or one at or above the worker count, there is no seed read and
// worker 0 seeds the search. The load store has one read port with registered
// data and one write port. The result sits in an output register, so the next
// item is accepted while it waits to be taken; if it is still waiting when the
// next result is ready, hold that item in its write-back cycle until the output
// frees up.
module least_loaded_assigner #(
  parameter int unsigned MAX_WORKERS = 8,
  parameter int unsigned LOAD_BITS   = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lla_pkg::CFG_W-1:0] cfg_wdata,
  lla_job_if.sink                   job,
  lla_result_if.source              res
);
  import lla_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: accept, take a fill load or seed and walk the loads, write back
  lla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (job.valid),
    .in_ready (job.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // load store, comparator, saturating adder and output register
  lla_datapath #(
    .MAX_WORKERS (MAX_WORKERS),
    .LOAD_BITS   (LOAD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .job_size     (job.job_size),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .worker_index (res.worker_index),
    .worker_load  (res.worker_load)
  );

endmodule

/* tb/least_loaded_assigner_test.sv */
`timescale 1ns / 1ps

module least_loaded_assigner_test;
  import lla_pkg::*;

  localparam int unsigned MAX_WORKERS = 8;
  localparam int unsigned LOAD_BITS   = 48;
  localparam int unsigned IDX_W       = $clog2(MAX_WORKERS);
  localparam int unsigned MAX_WAIT    = 18;   // longest idle either side draws per item
  localparam int unsigned SETTLE      = 16;   // idle time after the last result before a count write
  localparam int unsigned RANDOM_JOBS = 1900;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned LONG_HOLD   = 400;  // receiver hold-off that backs the block up
  localparam int unsigned NUM_ROWS    = 25;
  localparam logic [LOAD_BITS-1:0] LOAD_FULL = '1;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] worker;
    logic [LOAD_BITS-1:0] load;
  } assignment_t;

  typedef enum logic {ROW_JOB, ROW_SET_COUNT} row_kind_t;

  // One line of the directed plan: either a job item or a worker count write.
  // Where pinned is set, the expected assignment is written out in the row.
  typedef struct packed {
    row_kind_t            kind;
    logic [SIZE_W-1:0]    value;
    logic                 pinned;
    logic [IDX_OUT_W-1:0] worker;
    logic [LOAD_BITS-1:0] load;
  } row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lla_job_if                             job ();
  lla_result_if #(.LOAD_BITS(LOAD_BITS)) res ();

  least_loaded_assigner #(
    .MAX_WORKERS(MAX_WORKERS),
    .LOAD_BITS  (LOAD_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .job      (job),
    .res      (res)
  );

  always #2 clk = ~clk;

  // Shadow copy of the scheduler: per-worker load totals, how far the initial
  // fill has got, and the worker chosen by the last least-load search.
  logic [LOAD_BITS-1:0] shadow_load [MAX_WORKERS];
  int unsigned          shadow_filled;
  int unsigned          shadow_last_pick;
  bit                   shadow_have_pick;
  logic [CFG_W-1:0]     shadow_count;

  assignment_t awaited_assignments [$];
  int unsigned mismatches  = 0;
  bit          send_idles  = 1'b1;
  bit          take_idles  = 1'b1;
  int unsigned result_hold = 0;

  // Directed plan, starting from the reset count of seven workers.
  row_t directed_rows [NUM_ROWS] = '{
    // initial fill: workers 0 to 6 in order, size extremes among them
    '{ROW_JOB,       32'h0000_0000, 1'b1, 3'd0, 48'h0},
    '{ROW_JOB,       32'hFFFF_FFFF, 1'b1, 3'd1, 48'hFFFF_FFFF},
    '{ROW_JOB,       32'h0000_0001, 1'b1, 3'd2, 48'h1},
    '{ROW_JOB,       32'h0000_0005, 1'b1, 3'd3, 48'h5},
    '{ROW_JOB,       32'h0000_0007, 1'b1, 3'd4, 48'h7},
    '{ROW_JOB,       32'h0000_0000, 1'b1, 3'd5, 48'h0},
    '{ROW_JOB,       32'h0000_0002, 1'b1, 3'd6, 48'h2},
    // first search: workers 0 and 5 both empty, the lower index wins
    '{ROW_JOB,       32'h0000_000A, 1'b1, 3'd0, 48'hA},
    // later searches: ties keep the previous pick
    '{ROW_JOB,       32'h0000_0000, 1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h0000_0001, 1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h0000_0000, 1'b0, 3'd0, 48'h0},
    // count above the maximum acts as eight: the fill resumes with worker 7
    '{ROW_SET_COUNT, 32'd15,        1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h0000_0004, 1'b1, 3'd7, 48'h4},
    '{ROW_JOB,       32'h0000_0006, 1'b0, 3'd0, 48'h0},
    // count zero acts as one; the previous pick falls outside it
    '{ROW_SET_COUNT, 32'd0,         1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'hFFFF_FFFF, 1'b1, 3'd0, 48'h1_0000_0009},
    '{ROW_SET_COUNT, 32'd1,         1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h0000_0000, 1'b0, 3'd0, 48'h0},
    '{ROW_SET_COUNT, 32'd3,         1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h0000_0008, 1'b0, 3'd0, 48'h0},
    '{ROW_SET_COUNT, 32'd8,         1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'hFFFF_FFFF, 1'b0, 3'd0, 48'h0},
    '{ROW_SET_COUNT, 32'd9,         1'b0, 3'd0, 48'h0},
    '{ROW_JOB,       32'h8000_0000, 1'b0, 3'd0, 48'h0},
    '{ROW_SET_COUNT, 32'd7,         1'b0, 3'd0, 48'h0}
  };

  // Advance the shadow scheduler by one job and return where it lands.
  function automatic assignment_t place_job(logic [SIZE_W-1:0] size);
    int unsigned          active;
    int unsigned          pick;
    int unsigned          i;
    bit                   found;
    logic [LOAD_BITS-1:0] best;
    logic [LOAD_BITS:0]   sum;
    assignment_t          placed;
    active = (shadow_count == '0) ? 1 : 32'(shadow_count);
    if (active > MAX_WORKERS) active = MAX_WORKERS;
    if (shadow_filled < active) begin
      // still filling: next unfilled worker, no search
      pick = shadow_filled;
      shadow_filled++;
    end else begin
      found = 1'b0;
      best  = '0;
      pick  = 0;
      // start from the previous pick so that it wins ties, unless the count
      // has since dropped below it
      if (shadow_have_pick && shadow_last_pick < active) begin
        pick  = shadow_last_pick;
        best  = shadow_load[IDX_W'(pick)];
        found = 1'b1;
      end
      for (i = 0; i < active; i++) begin
        if (!found || shadow_load[IDX_W'(i)] < best) begin
          pick  = i;
          best  = shadow_load[IDX_W'(i)];
          found = 1'b1;
        end
      end
      shadow_last_pick = pick;
      shadow_have_pick = 1'b1;
    end
    // saturate on carry out of the load width
    sum = {1'b0, shadow_load[IDX_W'(pick)]} + (LOAD_BITS + 1)'(size);
    shadow_load[IDX_W'(pick)] = sum[LOAD_BITS] ? LOAD_FULL : sum[LOAD_BITS-1:0];
    placed.worker = IDX_OUT_W'(pick);
    placed.load   = shadow_load[IDX_W'(pick)];
    return placed;
  endfunction

  // Offer one job item, hold it until taken, then queue its expected result.
  // Within this task valid is only lowered when a gap is drawn, so back-to-back
  // items keep it high across the handshake.
  task automatic send_job(logic [SIZE_W-1:0] size, bit pinned,
                          logic [IDX_OUT_W-1:0] worker, logic [LOAD_BITS-1:0] load);
    int unsigned gap;
    assignment_t predicted;
    gap = send_idles ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      job.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job.valid    <= 1'b1;
    job.job_size <= size;
    do @(posedge clk); while (!job.ready);
    predicted = place_job(size);
    if (pinned) begin
      predicted.worker = worker;
      predicted.load   = load;
    end
    awaited_assignments.push_back(predicted);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain();
    job.valid <= 1'b0;
    while (awaited_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the worker count; only ever called with the block idle.
  task automatic set_count(logic [CFG_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count  = count;
  endtask

  // Result side: draw a stall per item (or take a pending long hold-off),
  // then take one result and compare it with the oldest expectation.
  initial begin : take_results
    int unsigned stall;
    assignment_t want;
    res.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = take_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (result_hold > 0) begin
        stall       = result_hold;
        result_hold = 0;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      if (awaited_assignments.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: worker %0d load %h",
                   res.worker_index, res.worker_load);
      end else begin
        want = awaited_assignments.pop_front();
        if (res.worker_index !== want.worker || res.worker_load !== want.load) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("assignment mismatch: expected worker %0d load %h, got worker %0d load %h",
                     want.worker, want.load, res.worker_index, res.worker_load);
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("least_loaded_assigner_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       k;
    logic [CFG_W-1:0]  count;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] prev_size;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    job.valid    <= 1'b0;
    job.job_size <= '0;

    foreach (shadow_load[w]) shadow_load[w] = '0;
    shadow_filled    = 0;
    shadow_last_pick = 0;
    shadow_have_pick = 1'b0;
    shadow_count     = WORKER_COUNT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed plan: fill order, tie rules, count extremes and count changes.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SET_COUNT) begin
        drain();
        set_count(directed_rows[r].value[CFG_W-1:0]);
      end else begin
        send_job(directed_rows[r].value, directed_rows[r].pinned,
                 directed_rows[r].worker, directed_rows[r].load);
      end
    end

    // Random phases: a fresh count per phase, each side idling or flat out.
    sent      = 0;
    phase     = 0;
    prev_size = '0;
    while (sent < RANDOM_JOBS) begin
      drain();
      case (phase % 6)
        0:       count = '1;
        1:       count = 4'd1;
        2:       count = 4'd0;
        3:       count = 4'd8;
        default: count = CFG_W'($urandom_range(0, 15));
      endcase
      set_count(count);
      send_idles = ($urandom_range(0, 3) != 0);
      take_idles = ($urandom_range(0, 3) != 0);
      phase_len  = $urandom_range(20, 120);
      // hold results back for a long stretch while items keep coming, so the
      // output register fills and the block stalls its input
      if (phase == 3) begin
        send_idles  = 1'b0;
        result_hold = LONG_HOLD;
      end
      for (k = 0; k < phase_len; k++) begin
        case ($urandom_range(0, 9))
          0:       size = '0;
          1:       size = '1;
          2, 3:    size = SIZE_W'($urandom_range(0, 15));
          4:       size = prev_size;
          default: size = $urandom();
        endcase
        send_job(size, 1'b0, '0, '0);
        prev_size = size;
      end
      sent += phase_len;
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("least_loaded_assigner_test: PASS");
    end else begin
      $display("least_loaded_assigner_test: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lla_pkg.sv
hw/rtl/lla_intf.sv
hw/rtl/lla_ctrl.sv
hw/rtl/lla_datapath.sv
hw/rtl/least_loaded_assigner.sv
tb/least_loaded_assigner_test.sv
